/* design/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Status codes, key characters, register indexes and the result record.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int StatusW  = 3;
  localparam int DigitsW  = 3;
  localparam int AttemptW = 3;
  localparam int SecondsW = 8;
  localparam int KeyW     = 8;
  localparam int CodeW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [StatusW-1:0] ST_IGNORED  = 3'd0;
  localparam logic [StatusW-1:0] ST_TAKEN    = 3'd1;
  localparam logic [StatusW-1:0] ST_REMOVED  = 3'd2;
  localparam logic [StatusW-1:0] ST_GRANTED  = 3'd3;
  localparam logic [StatusW-1:0] ST_DENIED   = 3'd4;
  localparam logic [StatusW-1:0] ST_LOCKED   = 3'd5;
  localparam logic [StatusW-1:0] ST_UNLOCKED = 3'd6;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [KeyW-1:0] KEY_ZERO  = 8'h30;
  localparam logic [KeyW-1:0] KEY_NINE  = 8'h39;
  localparam logic [KeyW-1:0] KEY_HASH  = 8'h23;
  localparam logic [KeyW-1:0] KEY_STAR  = 8'h2A;

  localparam logic [CfgIdxW-1:0] CFG_CODE_DIGITS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOCK_SECONDS = 2'd2;

  localparam logic [CodeW-1:0]    RST_CODE_DIGITS  = 16'h2222;
  localparam logic [AttemptW-1:0] RST_MAX_ATTEMPTS = 3'd3;
  localparam logic [SecondsW-1:0] RST_LOCK_SECONDS = 8'd30;

  localparam logic [AttemptW-1:0] FAIL_SAT = 3'd7;

  typedef struct packed {
    logic [SecondsW-1:0] seconds_left;
    logic [AttemptW-1:0] attempts_used;
    logic [DigitsW-1:0]  digits_entered;
    logic [StatusW-1:0]  status;
  } kcl_result_t;

  typedef struct packed {
    logic [CodeW-1:0]    code_digits;
    logic [AttemptW-1:0] max_attempts;
    logic [SecondsW-1:0] lock_seconds;
  } kcl_cfg_t;

endpackage

/* design/keypad_code_lock.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock: four-digit keypad code lock with lockout
// Stream in key presses and one-second ticks, stream out one status per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[0] is the item kind (0 key press, 1 tick), tdata[7:0]
//   is the ASCII key code. Every accepted item yields exactly one result on
//   the master stream: tdata[2:0] status, [5:3] digits entered, [8:6] failed
//   attempts, [16:9] lockout ticks left, upper bits zero.
//   Configuration: cfg_index_i 0 writes the BCD code, 1 the attempt limit,
//   2 the lockout length in ticks; other indexes are accepted and dropped.
//   Writes are always taken and must only be issued while the block is idle.
//   The result passes through one input register, then the update logic
//   feeding the result register; a stalled master side holds it back. One
//   item is accepted per cycle while the master side keeps taking results.
//   When the master side stalls, the result register holds and one more item
//   is parked in the input register before s_axis_tready drops.
//   Reset clears the counters, the lockout and both pipeline valid flags and
//   restores the code 2222, limit 3 and 30 ticks. The entry buffer is not
//   cleared; the digit count guards it.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] key_char
  input  logic [0:0]               s_axis_tuser,   // [0] kind
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [2:0] status, [5:3] digits_entered,
                                                   // [8:6] attempts_used, [16:9] seconds_left
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [kcl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kcl_pkg::CfgDataW-1:0] cfg_data_i
);
  import kcl_pkg::*;

  kcl_cfg_t    cfg_q;
  logic        in_vld_q;
  logic        in_kind_q;
  logic [7:0]  in_key_q;
  logic        out_vld_q;
  kcl_result_t out_q;
  kcl_result_t core_res;
  logic        step;

  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_digits  <= RST_CODE_DIGITS;
      cfg_q.max_attempts <= RST_MAX_ATTEMPTS;
      cfg_q.lock_seconds <= RST_LOCK_SECONDS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CODE_DIGITS:  cfg_q.code_digits  <= cfg_data_i;
        CFG_MAX_ATTEMPTS: cfg_q.max_attempts <= cfg_data_i[AttemptW-1:0];
        CFG_LOCK_SECONDS: cfg_q.lock_seconds <= cfg_data_i[SecondsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser[0];
      in_key_q  <= s_axis_tdata;
    end
    if (step) begin
      out_q <= core_res;
    end
  end

  kcl_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .kind_i    (in_kind_q),
    .key_char_i(in_key_q),
    .cfg_i     (cfg_q),
    .result_o  (core_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.seconds_left, out_q.attempts_used,
                          out_q.digits_entered, out_q.status};

  // An unlock always comes with a cleared failure count and timer.
  a_unlock_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status == ST_UNLOCKED) |->
      (out_q.attempts_used == '0 && out_q.seconds_left == '0))
    else $error("unlock result with nonzero count or timer");

  // A submission, granted or denied, always empties the entry buffer.
  a_submit_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.status == ST_GRANTED || out_q.status == ST_DENIED)) |->
      (out_q.digits_entered == '0))
    else $error("submission left digits in the buffer");

  // A parked item is never dropped while the output is stalled.
  a_parked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> in_vld_q)
    else $error("parked input item lost");

  // A new result is loaded only when the previous one was taken or absent.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result overwritten");

endmodule

/* design/kcl_core.sv */
// ----------------------------------------------------------------------------
// kcl_core: lock state and per-item update
// Holds the entry buffer, failure count and lockout timer, and works out the
// result of one item in a single pass.
// ----------------------------------------------------------------------------
module kcl_core #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                kind_i,
  input  logic [7:0]          key_char_i,
  input  kcl_pkg::kcl_cfg_t   cfg_i,
  output kcl_pkg::kcl_result_t result_o
);
  import kcl_pkg::*;

  localparam int CntW = $clog2(CODE_LENGTH + 1);
  localparam int IdxW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int CodeNibbles = CodeW / 4;

  logic [3:0]          entry_buf_q [CODE_LENGTH];
  logic [CntW-1:0]     entry_cnt_q, entry_cnt_d;
  logic [AttemptW-1:0] fail_cnt_q, fail_cnt_d;
  logic                lock_q, lock_d;
  logic [SecondsW-1:0] remain_q, remain_d;

  logic [CODE_LENGTH-1:0] nib_ok;
  logic                   match;
  logic                   is_digit;
  logic                   take;
  logic [AttemptW-1:0]    fail_inc;
  logic [StatusW-1:0]     status;
  logic [3:0]             digit;

  // Buffer slot i is compared with code nibble CODE_LENGTH-1-i; nibbles beyond
  // the register compare against zero.
  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
    localparam int Pos = CODE_LENGTH - 1 - i;
    if (Pos < CodeNibbles) begin : g_in
      assign nib_ok[i] = (entry_buf_q[i] == cfg_i.code_digits[4*Pos +: 4]);
    end else begin : g_out
      assign nib_ok[i] = (entry_buf_q[i] == 4'd0);
    end
  end
  assign match = &nib_ok;

  assign is_digit = (key_char_i >= KEY_ZERO) && (key_char_i <= KEY_NINE);
  assign digit    = 4'(key_char_i - KEY_ZERO);
  assign fail_inc = (fail_cnt_q == FAIL_SAT) ? fail_cnt_q : fail_cnt_q + 3'd1;

  always_comb begin
    entry_cnt_d = entry_cnt_q;
    fail_cnt_d  = fail_cnt_q;
    lock_d      = lock_q;
    remain_d    = remain_q;
    status      = ST_IGNORED;
    take        = 1'b0;
    if (kind_i == KIND_TICK) begin
      if (lock_q) begin
        if (remain_q <= 8'd1) begin
          remain_d   = '0;
          lock_d     = 1'b0;
          fail_cnt_d = '0;
          status     = ST_UNLOCKED;
        end else begin
          remain_d = remain_q - 8'd1;
          status   = ST_LOCKED;
        end
      end
    end else if (!lock_q) begin
      if (is_digit) begin
        if (entry_cnt_q < CntW'(CODE_LENGTH)) begin
          take        = 1'b1;
          entry_cnt_d = entry_cnt_q + 1'b1;
          status      = ST_TAKEN;
        end
      end else if (key_char_i == KEY_HASH) begin
        if (entry_cnt_q != '0) begin
          entry_cnt_d = entry_cnt_q - 1'b1;
          status      = ST_REMOVED;
        end
      end else if (key_char_i == KEY_STAR) begin
        if (entry_cnt_q == CntW'(CODE_LENGTH)) begin
          entry_cnt_d = '0;
          if (match) begin
            status = ST_GRANTED;
          end else begin
            fail_cnt_d = fail_inc;
            if (fail_inc >= cfg_i.max_attempts) begin
              lock_d   = 1'b1;
              remain_d = cfg_i.lock_seconds;
            end
            status = ST_DENIED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      fail_cnt_q  <= '0;
      lock_q      <= 1'b0;
      remain_q    <= '0;
    end else if (step_i) begin
      entry_cnt_q <= entry_cnt_d;
      fail_cnt_q  <= fail_cnt_d;
      lock_q      <= lock_d;
      remain_q    <= remain_d;
    end
  end

  // The entry buffer is payload only; slots are read only after being written.
  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_buf
    always_ff @(posedge clk_i) begin
      if (step_i && take && (entry_cnt_q[IdxW-1:0] == IdxW'(i))) begin
        entry_buf_q[i] <= digit;
      end
    end
  end

  assign result_o.status         = status;
  assign result_o.digits_entered = 3'(entry_cnt_d);
  assign result_o.attempts_used  = fail_cnt_d;
  assign result_o.seconds_left   = lock_d ? remain_d : '0;

endmodule
